// ===== hdl/gqg_pkg.sv =====
`default_nettype none
package gqg_pkg;
    localparam int GLYPH_ENTRIES = 128;
    localparam int SLOT_W = $clog2(GLYPH_ENTRIES);
    localparam int MAX_CHARS = 256;
    localparam int VCNT_W = 13;
    localparam logic [VCNT_W-1:0] VCNT_LIMIT = VCNT_W'(4 * MAX_CHARS - 4);
    localparam int KEY_W = 32;
    localparam int MET_W = 40;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [16:0] UV_ONE = 17'h10000;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_EMIT  = 2'd1,
        CMD_BEGIN = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [1:0] CFG_AW = 2'd0;
    localparam logic [1:0] CFG_AH = 2'd1;
    localparam logic [1:0] CFG_GIU = 2'd2;
    localparam logic [1:0] CFG_LS = 2'd3;

    typedef struct packed {
        logic        start;
        logic [12:0] num;
        logic [12:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [16:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== hdl/glyph_quad_generator.sv =====
`default_nettype none
// glyph_quad_generator: lays out bitmap-font text as textured quads
// input beats carry commands: load a glyph table slot, emit a character or
// begin a string. a found glyph yields four output beats, one per quad corner
// (top-left, top-right, bottom-right, bottom-left), tlast on the fourth.
// a load, a begin or a newline passes through the command state and back to
// idle; a character scans the glyph table one entry a cycle through the key
// memory, then, unless the vertex count is past its limit, four serial uv
// divisions run on one shared divider, then four output beats, one a cycle
// while the receiver takes them. one item is handled at a time; i_s_tready is
// low while an item is in work. a stall on the output holds the corner beat
// and the block until taken. after reset the pen, vertex count and config
// registers take their reset values; the glyph memories hold nothing defined
// until loaded. configuration is written through i_cfg_we / i_cfg_index /
// i_cfg_data, by the user only while idle; the block does not enforce this.
module glyph_quad_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // cmd, slot, char_code, atlas_x, atlas_y, glyph_w, glyph_h, offset_x,
    // offset_y, advance, zero pad to 88
    input  wire logic [87:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // pos_x, pos_y, tex_u, tex_v, vertex_number, corner, zero pad to 80
    output logic [79:0]      o_m_tdata,
    output logic             o_m_tlast
);
    import gqg_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CMD  = 7'b0000010,
        ST_SCAN = 7'b0000100,
        ST_META = 7'b0001000,
        ST_DIVS = 7'b0010000,
        ST_DIVW = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    logic [87:0] r_in;
    logic [12:0] r_aw, r_ah;
    logic [7:0]  r_giu, r_ls;
    logic [15:0] r_pen_x, r_pen_y;
    logic [VCNT_W-1:0] r_vcnt;
    logic [SLOT_W:0] r_idx;
    logic [SLOT_W:0] r_limit;
    logic [KEY_W-1:0] r_key;
    logic [MET_W-1:0] r_met;
    logic [1:0]  r_dsel;
    logic [16:0] r_u0, r_u1, r_v0, r_v1;
    logic [1:0]  r_corner;
    logic        r_ovalid;

    logic [1:0]  w_cmd;
    logic [SLOT_W-1:0] w_slot;
    logic [7:0]  w_code;
    logic        w_load;
    logic [KEY_W-1:0] w_key_wr, w_key_rd;
    logic [MET_W-1:0] w_met_wr, w_met_rd;
    logic [SLOT_W-1:0] w_raddr;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;

    assign w_cmd  = i_s_tdata[1:0];
    assign w_slot = i_s_tdata[2 +: SLOT_W];
    assign w_code = r_in[16:9];
    assign w_load = (r_state == ST_IDLE) && i_s_tvalid && (t_cmd'(w_cmd) == CMD_LOAD);
    assign w_key_wr = {i_s_tdata[40:29], i_s_tdata[28:17], i_s_tdata[16:9]};
    assign w_met_wr = i_s_tdata[80:41];
    assign w_raddr  = r_idx[SLOT_W-1:0];

    gqg_ram #(.WIDTH(KEY_W), .DEPTH(GLYPH_ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(w_load), .i_waddr(w_slot), .i_wdata(w_key_wr),
        .i_raddr(w_raddr), .o_rdata(w_key_rd)
    );
    gqg_ram #(.WIDTH(MET_W), .DEPTH(GLYPH_ENTRIES)) u_met (
        .i_clk(i_clk), .i_we(w_load), .i_waddr(w_slot), .i_wdata(w_met_wr),
        .i_raddr(w_raddr), .o_rdata(w_met_rd)
    );

    always_comb begin
        w_dreq.start = (r_state == ST_DIVS);
        if (r_dsel[1]) begin
            w_dreq.den = r_ah;
            w_dreq.num = r_dsel[0] ? (13'(r_key[31:20]) + 13'(r_met[15:8]))
                                   : 13'(r_key[31:20]);
        end else begin
            w_dreq.den = r_aw;
            w_dreq.num = r_dsel[0] ? (13'(r_key[19:8]) + 13'(r_met[7:0]))
                                   : 13'(r_key[19:8]);
        end
    end

    gqg_uvdiv u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    logic [SLOT_W:0] w_giu_lim;
    assign w_giu_lim = (9'(r_giu) > 9'(GLYPH_ENTRIES)) ? (SLOT_W+1)'(GLYPH_ENTRIES)
                                                       : (SLOT_W+1)'(r_giu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_aw     <= 13'd256;
            r_ah     <= 13'd256;
            r_giu    <= 8'd0;
            r_ls     <= 8'd32;
            r_pen_x  <= '0;
            r_pen_y  <= '0;
            r_vcnt   <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AW:  r_aw <= i_cfg_data;
                    CFG_AH:  r_ah <= i_cfg_data;
                    CFG_GIU: r_giu <= i_cfg_data[7:0];
                    CFG_LS:  r_ls <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_in    <= i_s_tdata;
                        r_idx   <= '0;
                        r_limit <= w_giu_lim;
                        r_state <= ST_CMD;
                    end
                end
                ST_CMD: begin
                    case (t_cmd'(r_in[1:0]))
                        CMD_BEGIN: begin
                            r_pen_x <= '0;
                            r_pen_y <= '0;
                            r_vcnt  <= '0;
                            r_state <= ST_IDLE;
                        end
                        CMD_EMIT: begin
                            if (w_code == NEWLINE_CODE) begin
                                r_pen_x <= '0;
                                r_pen_y <= r_pen_y + 16'(r_ls);
                                r_state <= ST_IDLE;
                            end else if (r_limit != '0) begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= ST_SCAN;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_SCAN: begin
                    // memory output is entry r_idx-1
                    if (w_key_rd[7:0] == w_code) begin
                        r_key   <= w_key_rd;
                        r_met   <= w_met_rd;
                        r_state <= ST_META;
                    end else if (r_idx == r_limit) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_META: begin
                    r_dsel <= 2'd0;
                    r_state <= (r_vcnt > VCNT_LIMIT) ? ST_IDLE : ST_DIVS;
                end
                ST_DIVS: r_state <= ST_DIVW;
                ST_DIVW: begin
                    if (w_drsp.done) begin
                        case (r_dsel)
                            2'd0: r_u0 <= w_drsp.quo;
                            2'd1: r_u1 <= w_drsp.quo;
                            2'd2: r_v0 <= UV_ONE - w_drsp.quo;
                            default: r_v1 <= UV_ONE - w_drsp.quo;
                        endcase
                        r_dsel <= r_dsel + 2'd1;
                        if (r_dsel == 2'd3) begin
                            r_corner <= 2'd0;
                            r_ovalid <= 1'b1;
                            r_state  <= ST_OUT;
                        end else begin
                            r_state <= ST_DIVS;
                        end
                    end
                end
                ST_OUT: begin
                    if (i_m_tready) begin
                        r_corner <= r_corner + 2'd1;
                        if (r_corner == 2'd3) begin
                            r_ovalid <= 1'b0;
                            r_vcnt   <= r_vcnt + VCNT_W'(4);
                            r_pen_x  <= r_pen_x + 16'(r_met[39:32]);
                            r_state  <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    logic        w_right, w_bottom;
    logic [15:0] w_px, w_py;
    logic [VCNT_W-1:0] w_vn;

    always_comb begin
        w_right  = (r_corner == 2'd1) || (r_corner == 2'd2);
        w_bottom = r_corner[1];
        w_px = r_pen_x + {{8{r_met[23]}}, r_met[23:16]}
             + (w_right ? 16'(r_met[7:0]) : 16'd0);
        w_py = r_pen_y + {{8{r_met[31]}}, r_met[31:24]}
             + (w_bottom ? 16'(r_met[15:8]) : 16'd0);
        w_vn = r_vcnt + VCNT_W'(r_corner);
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = (r_corner == 2'd3);
    assign o_m_tdata  = {2'b00, r_corner, w_vn[9:0],
                         w_bottom ? r_v1 : r_v0, w_right ? r_u1 : r_u0, w_py, w_px};
endmodule
`default_nettype wire

// ===== hdl/gqg_ram.sv =====
`default_nettype none
module gqg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/gqg_uvdiv.sv =====
`default_nettype none
module gqg_uvdiv (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  gqg_pkg::t_div_req        i_req,
    output gqg_pkg::t_div_rsp        o_rsp
);
    import gqg_pkg::*;

    // restoring division of num<<16 by den, one quotient bit a cycle
    logic [28:0] r_num;
    logic [12:0] r_den;
    logic [13:0] r_rem;
    logic [28:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [13:0] n_trial;
    logic [13:0] n_shift;

    always_comb begin
        n_shift = {r_rem[12:0], r_num[28]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 5'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd28;
                r_num  <= {i_req.num, 16'd0};
                r_den  <= (i_req.den == 13'd0) ? 13'd1 : i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[27:0], 1'b0};
                if (!n_trial[13]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[27:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[27:0], 1'b0};
                end
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        o_rsp.quo  = (r_quo > 29'(UV_ONE)) ? UV_ONE : r_quo[16:0];
    end
endmodule
`default_nettype wire

// ===== hdl/gqg_checker.sv =====
`default_nettype none
module gqg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [79:0] o_m_tdata,
    input wire logic        o_m_tlast
);
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(i_s_tvalid && o_s_tready))
        else $error("input taken while output pending");
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tdata[77:76] == 2'd3)))
        else $error("tlast mismatch");
    a_corner_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=>
        (o_m_tvalid && o_m_tdata[77:76] == $past(o_m_tdata[77:76]) + 2'd1))
        else $error("corner sequence broken");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled beat changed");
endmodule

bind glyph_quad_generator gqg_checker u_gqg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready), .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
);
`default_nettype wire

// ===== tb/quad_corner_checker.sv =====
`timescale 1ns / 1ps
module quad_corner_checker
    import gqg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [87:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [79:0] i_m_tdata,
    input  wire logic        i_m_tlast,
    output int               o_errors,
    output int               o_pending
);
    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [9:0]  vnum;
        logic [1:0]  corner;
        logic        last;
    } t_corner;

    logic [7:0]  key_code [GLYPH_ENTRIES];
    logic [11:0] key_ax [GLYPH_ENTRIES];
    logic [11:0] key_ay [GLYPH_ENTRIES];
    logic [7:0]  met_w [GLYPH_ENTRIES];
    logic [7:0]  met_h [GLYPH_ENTRIES];
    logic [7:0]  met_ox [GLYPH_ENTRIES];
    logic [7:0]  met_oy [GLYPH_ENTRIES];
    logic [7:0]  met_adv [GLYPH_ENTRIES];

    logic [15:0] pen_x, pen_y;
    int          vtx_count;
    logic [12:0] atlas_w, atlas_h;
    logic [7:0]  glyphs_used, line_step;
    t_corner     expected_corners[$];
    int          errors;

    function automatic logic [16:0] uv_frac(input int unsigned num, input logic [12:0] den);
        longint unsigned d;
        longint unsigned q;
        d = (den == 0) ? 1 : den;
        q = (longint'(num) << 16) / d;
        return (q > UV_ONE) ? UV_ONE : q[16:0];
    endfunction

    task automatic layout_item(input logic [87:0] d);
        t_cmd        cmd;
        logic [7:0]  code;
        int          slot, lim, hit;
        int unsigned ax, ay, w, h;
        logic [15:0] x0, y0;
        logic [16:0] u0, u1, v0, v1;
        t_corner     c;
        cmd  = t_cmd'(d[1:0]);
        slot = d[8:2];
        code = d[16:9];
        case (cmd)
            CMD_LOAD: begin
                key_code[slot] = code;
                key_ax[slot]   = d[28:17];
                key_ay[slot]   = d[40:29];
                met_w[slot]    = d[48:41];
                met_h[slot]    = d[56:49];
                met_ox[slot]   = d[64:57];
                met_oy[slot]   = d[72:65];
                met_adv[slot]  = d[80:73];
            end
            CMD_BEGIN: begin
                pen_x = '0;
                pen_y = '0;
                vtx_count = 0;
            end
            CMD_EMIT: begin
                if (code == NEWLINE_CODE) begin
                    pen_x = '0;
                    pen_y = pen_y + 16'(line_step);
                end else begin
                    lim = (glyphs_used < GLYPH_ENTRIES) ? glyphs_used : GLYPH_ENTRIES;
                    hit = -1;
                    for (int i = 0; i < lim; i++) begin
                        if (hit < 0 && key_code[i] == code) hit = i;
                    end
                    if (hit >= 0 && vtx_count + 4 <= 4 * MAX_CHARS) begin
                        ax = key_ax[hit];
                        ay = key_ay[hit];
                        w  = met_w[hit];
                        h  = met_h[hit];
                        x0 = pen_x + {{8{met_ox[hit][7]}}, met_ox[hit]};
                        y0 = pen_y + {{8{met_oy[hit][7]}}, met_oy[hit]};
                        u0 = uv_frac(ax, atlas_w);
                        u1 = uv_frac(ax + w, atlas_w);
                        v0 = UV_ONE - uv_frac(ay, atlas_h);
                        v1 = UV_ONE - uv_frac(ay + h, atlas_h);
                        for (int k = 0; k < 4; k++) begin
                            c.pos_x  = x0 + ((k == 1 || k == 2) ? 16'(w) : 16'd0);
                            c.pos_y  = y0 + ((k >= 2) ? 16'(h) : 16'd0);
                            c.tex_u  = (k == 1 || k == 2) ? u1 : u0;
                            c.tex_v  = (k >= 2) ? v1 : v0;
                            c.vnum   = 10'(vtx_count + k);
                            c.corner = 2'(k);
                            c.last   = (k == 3);
                            expected_corners.push_back(c);
                        end
                        vtx_count += 4;
                        pen_x = pen_x + 16'(met_adv[hit]);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned e, input int unsigned a);
        if (e != a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
        end
    endtask

    always @(posedge i_clk) begin
        t_corner e;
        if (!i_rst_n) begin
            pen_x = '0;
            pen_y = '0;
            vtx_count = 0;
            atlas_w = 13'd256;
            atlas_h = 13'd256;
            glyphs_used = 8'd0;
            line_step = 8'd32;
            expected_corners.delete();
            errors = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_corners.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, got %h last %b", $time, i_m_tdata, i_m_tlast);
                end else begin
                    e = expected_corners.pop_front();
                    check_field("pos_x", e.pos_x, i_m_tdata[15:0]);
                    check_field("pos_y", e.pos_y, i_m_tdata[31:16]);
                    check_field("tex_u", e.tex_u, i_m_tdata[48:32]);
                    check_field("tex_v", e.tex_v, i_m_tdata[65:49]);
                    check_field("vertex_number", e.vnum, i_m_tdata[75:66]);
                    check_field("corner", e.corner, i_m_tdata[77:76]);
                    check_field("last", e.last, i_m_tlast);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AW:  atlas_w = i_cfg_data;
                    CFG_AH:  atlas_h = i_cfg_data;
                    CFG_GIU: glyphs_used = i_cfg_data[7:0];
                    CFG_LS:  line_step = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) layout_item(i_s_tdata);
        end
        o_errors  <= errors;
        o_pending <= expected_corners.size();
    end
endmodule

// ===== tb/tb_glyph_quad_generator.sv =====
`timescale 1ns / 1ps
module tb_glyph_quad_generator;
    import gqg_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 300;
    localparam logic [7:0] ABSENT_CODE = 8'd200;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [87:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [79:0] o_m_tdata;
    logic        o_m_tlast;

    int          errors, pending;
    int          cycles = 0;
    logic        hold_off_req = 0;
    logic [7:0]  loaded_code [GLYPH_ENTRIES];

    always #2 i_clk = ~i_clk;

    glyph_quad_generator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast)
    );

    quad_corner_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_m_tlast(o_m_tlast), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [87:0] pack_item(input t_cmd cmd, input logic [6:0] slot,
            input logic [7:0] code, input logic [11:0] ax, input logic [11:0] ay,
            input logic [7:0] w, input logic [7:0] h, input logic [7:0] ox,
            input logic [7:0] oy, input logic [7:0] adv);
        return {7'd0, adv, oy, ox, h, w, ay, ax, code, slot, cmd};
    endfunction

    function automatic logic [87:0] random_load(input int slot, input logic [7:0] code);
        return pack_item(CMD_LOAD, 7'(slot), code, 12'($urandom), 12'($urandom),
            8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic logic [87:0] emit(input logic [7:0] code);
        return pack_item(CMD_EMIT, 7'($urandom), code, 12'($urandom), 12'($urandom),
            8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic logic [7:0] stored_code();
        logic [7:0] c;
        c = 8'($urandom);
        while (c == ABSENT_CODE) c = 8'($urandom);
        return c;
    endfunction

    task automatic send(input logic [87:0] d);
        int gap;
        int r;
        r = $urandom_range(99);
        gap = (r < 65) ? 0 : (r < 94) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        if (gap > 0) begin
            i_s_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        if (d[1:0] == CMD_LOAD) loaded_code[d[8:2]] = d[16:9];
        i_s_tvalid = 1;
        i_s_tdata = d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_s_tvalid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic set_regs(input logic [12:0] aw, input logic [12:0] ah,
            input logic [7:0] giu, input logic [7:0] ls);
        write_reg(CFG_AW, aw);
        write_reg(CFG_AH, ah);
        write_reg(CFG_GIU, 13'(giu));
        write_reg(CFG_LS, 13'(ls));
    endtask

    task automatic random_run(input int n, input bit with_begin);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 8) send(random_load($urandom_range(127), stored_code()));
            else if (r < 20) send(emit(NEWLINE_CODE));
            else if (r < 22) send(pack_item(CMD_NONE, 7'($urandom), 8'($urandom),
                12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom)));
            else if (with_begin && r < 26) send(pack_item(CMD_BEGIN, 7'($urandom),
                8'($urandom), 12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom)));
            else if (r < 90) send(emit(loaded_code[$urandom_range(127)]));
            else send(emit(8'($urandom)));
        end
    endtask

    // receiver: bursts of always-ready, bursts of random stalls, one long hold-off
    initial begin
        int stretch;
        bit busy;
        stretch = 0;
        busy = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_m_tready = 0;
                repeat (3000) @(negedge i_clk);
                hold_off_req = 0;
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(10, 100);
                    busy = $urandom_range(1);
                end
                stretch--;
                if (!busy) i_m_tready = 1;
                else if ($urandom_range(49) == 0) begin
                    i_m_tready = 0;
                    repeat ($urandom_range(20, 60)) @(negedge i_clk);
                end else i_m_tready = ($urandom_range(9) > 2);
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        set_regs(13'd1, 13'd4096, 8'd128, 8'd255);
        for (int s = 0; s < GLYPH_ENTRIES; s++) send(random_load(s, stored_code()));

        // extremes, duplicate code, missing code, newline, unknown command
        send(pack_item(CMD_LOAD, 7'd0, 8'd65, 12'hfff, 12'hfff, 8'hff, 8'hff,
            8'h80, 8'h7f, 8'hff));
        send(pack_item(CMD_LOAD, 7'd1, 8'd66, 12'h000, 12'h000, 8'h00, 8'h00,
            8'h7f, 8'h80, 8'h00));
        send(pack_item(CMD_LOAD, 7'd2, 8'd65, 12'h123, 12'h456, 8'h10, 8'h20,
            8'h01, 8'hff, 8'h08));
        send(pack_item(CMD_BEGIN, 7'h7f, 8'hff, 12'hfff, 12'hfff, 8'hff, 8'hff,
            8'hff, 8'hff, 8'hff));
        send(emit(8'd65));
        send(emit(8'd66));
        send(emit(NEWLINE_CODE));
        send(emit(8'd65));
        send(emit(ABSENT_CODE));
        send(pack_item(CMD_NONE, 7'h7f, 8'd65, 12'hfff, 12'hfff, 8'hff, 8'hff,
            8'hff, 8'hff, 8'hff));
        send(emit(8'd66));
        send(pack_item(CMD_LOAD, 7'd127, 8'd67, 12'd5, 12'd9, 8'd3, 8'd4,
            8'd0, 8'd0, 8'd7));
        send(emit(8'd67));
        settle();

        // zero atlas sizes, empty search, zero line step
        set_regs(13'd0, 13'd0, 8'd0, 8'd0);
        send(emit(8'd65));
        send(emit(NEWLINE_CODE));
        settle();
        set_regs(13'd0, 13'd0, 8'd3, 8'd0);
        send(emit(8'd66));
        send(emit(NEWLINE_CODE));
        send(emit(8'd65));
        settle();
        set_regs(13'd4096, 13'd1, 8'd3, 8'd17);
        send(emit(8'd65));
        send(emit(8'd66));
        settle();

        // long run with no begin
        set_regs(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), 8'd255,
            8'($urandom));
        random_run(160, 0);
        settle();

        set_regs(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
            8'($urandom_range(1, 255)), 8'($urandom));
        hold_off_req = 1;
        random_run(62, 1);
        settle();

        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/gqg_pkg.sv
hdl/gqg_ram.sv
hdl/gqg_uvdiv.sv
hdl/glyph_quad_generator.sv
hdl/gqg_checker.sv
tb/quad_corner_checker.sv
tb/tb_glyph_quad_generator.sv
